FILE: design/plm_pkg.sv
package plm_pkg;

    // Fixed field widths of the register and payload fields
    localparam int COUNT_BITS     = 4;
    localparam int GAIN_BITS      = 16;
    localparam int GAIN_FRAC_BITS = 12;
    localparam int CFG_DATA_BITS  = 16;
    localparam int CFG_INDEX_BITS = 1;

    // Register indexes on the configuration port
    localparam logic [CFG_INDEX_BITS-1:0] REG_CHANNEL_COUNT = 1'd0;
    localparam logic [CFG_INDEX_BITS-1:0] REG_VOLUME_GAIN   = 1'd1;

    // Register reset values; unity gain in Q4.12
    localparam logic [COUNT_BITS-1:0] RESET_CHANNEL_COUNT = 4'd2;
    localparam logic [GAIN_BITS-1:0]  UNITY_GAIN          = 16'd4096;

    // Commands from the controller to the datapath
    typedef struct packed {
        logic accept;
        logic sum_clear;
        logic sum_step;
        logic peak_clear;
        logic div_start;
        logic div_sel_level;
        logic out_load;
    } ctrl_cmd_t;

    // Status from the datapath to the controller
    typedef struct packed {
        logic sum_last;
        logic div_done;
        logic out_busy;
    } dp_status_t;

endpackage

FILE: design/plm_div.sv
module plm_div #(
    parameter int DIVIDEND_BITS = 36,
    parameter int DIVISOR_BITS  = 16
) (
    input  logic                     clk,
    input  logic                     rst_n,
    input  logic                     start,
    input  logic [DIVIDEND_BITS-1:0] dividend,
    input  logic [DIVISOR_BITS-1:0]  divisor,
    output logic                     done,
    output logic [DIVIDEND_BITS-1:0] quotient
);

    localparam int CNT_BITS = $clog2(DIVIDEND_BITS + 1);

    logic                     busy_reg;
    logic                     busy_next;
    logic [CNT_BITS-1:0]      cnt_reg;
    logic [CNT_BITS-1:0]      cnt_next;
    logic [DIVISOR_BITS-1:0]  rem_reg;
    logic [DIVISOR_BITS-1:0]  rem_next;
    logic [DIVIDEND_BITS-1:0] quo_reg;
    logic [DIVIDEND_BITS-1:0] quo_next;
    logic [DIVISOR_BITS-1:0]  dsr_reg;
    logic [DIVISOR_BITS-1:0]  dsr_next;
    logic [DIVISOR_BITS:0]    rem_shift;
    logic [DIVISOR_BITS:0]    rem_trial;
    logic                     fits;

    // One restoring step: shift in the next dividend bit, subtract if it fits
    assign rem_shift = {rem_reg, quo_reg[DIVIDEND_BITS-1]};
    assign fits      = rem_shift >= {1'b0, dsr_reg};
    assign rem_trial = rem_shift - {1'b0, dsr_reg};

    always_comb
    begin
        busy_next = busy_reg;
        cnt_next  = cnt_reg;
        rem_next  = rem_reg;
        quo_next  = quo_reg;
        dsr_next  = dsr_reg;
        if (start)
        begin
            busy_next = 1'b1;
            cnt_next  = CNT_BITS'(DIVIDEND_BITS);
            rem_next  = '0;
            quo_next  = dividend;
            dsr_next  = divisor;
        end
        else if (busy_reg)
        begin
            rem_next = fits ? rem_trial[DIVISOR_BITS-1:0] : rem_shift[DIVISOR_BITS-1:0];
            quo_next = {quo_reg[DIVIDEND_BITS-2:0], fits};
            cnt_next = cnt_reg - CNT_BITS'(1);
            if (cnt_reg == CNT_BITS'(1))
            begin
                busy_next = 1'b0;
            end
        end
    end

    // Hold control state under reset
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            busy_reg <= 1'b0;
            cnt_reg  <= '0;
        end
        else
        begin
            busy_reg <= busy_next;
            cnt_reg  <= cnt_next;
        end
    end

    // Advance the working registers
    always_ff @(posedge clk)
    begin
        rem_reg <= rem_next;
        quo_reg <= quo_next;
        dsr_reg <= dsr_next;
    end

    assign done     = busy_reg && (cnt_reg == CNT_BITS'(1));
    assign quotient = quo_reg;

endmodule

FILE: design/plm_datapath.sv
module plm_datapath #(
    parameter int MAX_CHANNELS = 8,
    parameter int SAMPLE_BITS  = 24
) (
    input  logic                                   clk,
    input  logic                                   rst_n,
    input  logic                                   cfg_wr_en,
    input  logic [plm_pkg::CFG_INDEX_BITS-1:0]     cfg_index,
    input  logic [plm_pkg::CFG_DATA_BITS-1:0]      cfg_wdata,
    input  logic signed [SAMPLE_BITS-1:0]          sample,
    input  logic                                   last_of_block,
    input  logic                                   out_ready,
    output logic                                   out_valid,
    output logic [SAMPLE_BITS-1:0]                 held_peak,
    input  plm_pkg::ctrl_cmd_t                     cmd,
    output plm_pkg::dp_status_t                    status
);

    import plm_pkg::*;

    localparam int POS_BITS = (MAX_CHANNELS > 1) ? $clog2(MAX_CHANNELS) : 1;
    localparam int NUM_BITS = $clog2(MAX_CHANNELS + 1);
    localparam int CMP_BITS = (NUM_BITS > COUNT_BITS) ? NUM_BITS : COUNT_BITS;
    localparam int SUM_BITS = SAMPLE_BITS + POS_BITS;
    localparam int DIV_BITS = SAMPLE_BITS + GAIN_FRAC_BITS;

    logic [COUNT_BITS-1:0]  count_reg;
    logic [GAIN_BITS-1:0]   gain_reg;
    logic [POS_BITS-1:0]    pos_reg;
    logic [POS_BITS-1:0]    pos_next;
    logic [SAMPLE_BITS-1:0] staging_reg [MAX_CHANNELS];
    logic [SAMPLE_BITS-1:0] peak_reg    [MAX_CHANNELS];
    logic [SAMPLE_BITS-1:0] peak_next   [MAX_CHANNELS];
    logic [SUM_BITS-1:0]    sum_reg;
    logic [SUM_BITS-1:0]    sum_next;
    logic [NUM_BITS-1:0]    nz_reg;
    logic [NUM_BITS-1:0]    nz_next;
    logic [POS_BITS-1:0]    sum_idx_reg;
    logic [POS_BITS-1:0]    sum_idx_next;
    logic [SAMPLE_BITS-1:0] held_reg;
    logic [SAMPLE_BITS-1:0] held_next;
    logic                   out_valid_reg;
    logic                   out_valid_next;

    logic [CMP_BITS-1:0]    count_ext;
    logic [NUM_BITS-1:0]    active_n;
    logic [SAMPLE_BITS-1:0] sample_u;
    logic [SAMPLE_BITS-1:0] mag;
    logic                   frame_done;
    logic [SAMPLE_BITS-1:0] sum_peak;
    logic [NUM_BITS-1:0]    nz_div;
    logic [GAIN_BITS-1:0]   gain_eff;
    logic [DIV_BITS-1:0]    div_dividend;
    logic [GAIN_BITS-1:0]   div_divisor;
    logic                   div_done;
    logic [DIV_BITS-1:0]    div_quotient;
    logic [SAMPLE_BITS-1:0] avg;
    logic [SAMPLE_BITS-1:0] level;

    // Clamp the channel count into one to MAX_CHANNELS
    always_comb
    begin
        count_ext = CMP_BITS'(count_reg);
        if (count_ext == '0)
        begin
            active_n = NUM_BITS'(1);
        end
        else if (count_ext > CMP_BITS'(MAX_CHANNELS))
        begin
            active_n = NUM_BITS'(MAX_CHANNELS);
        end
        else
        begin
            active_n = NUM_BITS'(count_ext);
        end
    end

    // Take the exact magnitude; the most negative code maps to 2^(N-1)
    assign sample_u   = sample;
    assign mag        = sample_u[SAMPLE_BITS-1] ? (~sample_u + SAMPLE_BITS'(1)) : sample_u;
    assign frame_done = (NUM_BITS'(pos_reg) + NUM_BITS'(1)) >= active_n;

    // Step the frame position; drop partial frames at block end
    always_comb
    begin
        pos_next = pos_reg;
        if (cmd.accept)
        begin
            if (last_of_block || frame_done)
            begin
                pos_next = '0;
            end
            else
            begin
                pos_next = pos_reg + POS_BITS'(1);
            end
        end
    end

    // Fold a completed frame into the channel peaks, lane by lane
    always_comb
    begin
        logic [SAMPLE_BITS-1:0] view;
        for (int c = 0; c < MAX_CHANNELS; c++)
        begin
            view         = (POS_BITS'(c) == pos_reg) ? mag : staging_reg[c];
            peak_next[c] = peak_reg[c];
            if (cmd.peak_clear)
            begin
                peak_next[c] = '0;
            end
            else if (cmd.accept && frame_done && (NUM_BITS'(c) < active_n)
                     && (view > peak_reg[c]))
            begin
                peak_next[c] = view;
            end
        end
    end

    // Accumulate the peak sum and the nonzero count, one channel a cycle
    assign sum_peak = peak_reg[sum_idx_reg];

    always_comb
    begin
        sum_next     = sum_reg;
        nz_next      = nz_reg;
        sum_idx_next = sum_idx_reg;
        if (cmd.sum_clear)
        begin
            sum_next     = '0;
            nz_next      = '0;
            sum_idx_next = '0;
        end
        else if (cmd.sum_step)
        begin
            sum_next     = sum_reg + SUM_BITS'(sum_peak);
            nz_next      = nz_reg + NUM_BITS'(sum_peak != '0);
            sum_idx_next = sum_idx_reg + POS_BITS'(1);
        end
    end

    // Select operands for the shared divider: average first, then gain
    assign nz_div       = (nz_reg == '0) ? NUM_BITS'(1) : nz_reg;
    assign gain_eff     = (gain_reg == '0) ? UNITY_GAIN : gain_reg;
    assign avg          = div_quotient[SAMPLE_BITS-1:0];
    assign div_dividend = cmd.div_sel_level ? {avg, {GAIN_FRAC_BITS{1'b0}}}
                                            : DIV_BITS'(sum_reg);
    assign div_divisor  = cmd.div_sel_level ? gain_eff : GAIN_BITS'(nz_div);

    plm_div #(
        .DIVIDEND_BITS (DIV_BITS),
        .DIVISOR_BITS  (GAIN_BITS)
    ) u_div (
        .clk      (clk),
        .rst_n    (rst_n),
        .start    (cmd.div_start),
        .dividend (div_dividend),
        .divisor  (div_divisor),
        .done     (div_done),
        .quotient (div_quotient)
    );

    // Saturate the scaled level and max-hold it
    assign level = (|div_quotient[DIV_BITS-1:SAMPLE_BITS]) ? '1
                                                          : div_quotient[SAMPLE_BITS-1:0];

    always_comb
    begin
        held_next      = held_reg;
        out_valid_next = out_valid_reg;
        if (out_ready)
        begin
            out_valid_next = 1'b0;
        end
        if (cmd.out_load)
        begin
            out_valid_next = 1'b1;
            if (level > held_reg)
            begin
                held_next = level;
            end
        end
    end

    // Hold registers and state that reset defines
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            count_reg     <= RESET_CHANNEL_COUNT;
            gain_reg      <= UNITY_GAIN;
            pos_reg       <= '0;
            held_reg      <= '0;
            out_valid_reg <= 1'b0;
            sum_idx_reg   <= '0;
            for (int c = 0; c < MAX_CHANNELS; c++)
            begin
                peak_reg[c] <= '0;
            end
        end
        else
        begin
            if (cfg_wr_en)
            begin
                case (cfg_index)
                    REG_CHANNEL_COUNT: count_reg <= cfg_wdata[COUNT_BITS-1:0];
                    REG_VOLUME_GAIN:   gain_reg  <= cfg_wdata[GAIN_BITS-1:0];
                    default:           ;
                endcase
            end
            pos_reg       <= pos_next;
            held_reg      <= held_next;
            out_valid_reg <= out_valid_next;
            sum_idx_reg   <= sum_idx_next;
            for (int c = 0; c < MAX_CHANNELS; c++)
            begin
                peak_reg[c] <= peak_next[c];
            end
        end
    end

    // Stage the frame in progress and the running sum
    always_ff @(posedge clk)
    begin
        if (cmd.accept)
        begin
            staging_reg[pos_reg] <= mag;
        end
        sum_reg <= sum_next;
        nz_reg  <= nz_next;
    end

    assign status.sum_last = (NUM_BITS'(sum_idx_reg) == (active_n - NUM_BITS'(1)));
    assign status.div_done = div_done;
    assign status.out_busy = out_valid_reg && !out_ready;

    assign out_valid = out_valid_reg;
    assign held_peak = held_reg;

endmodule

FILE: design/plm_ctrl.sv
module plm_ctrl (
    input  logic                clk,
    input  logic                rst_n,
    input  logic                in_valid,
    input  logic                last_of_block,
    output logic                in_ready,
    input  plm_pkg::dp_status_t status,
    output plm_pkg::ctrl_cmd_t  cmd
);

    import plm_pkg::*;

    localparam logic [2:0] S_IDLE     = 3'd0;
    localparam logic [2:0] S_SUM      = 3'd1;
    localparam logic [2:0] S_AVG_GO   = 3'd2;
    localparam logic [2:0] S_AVG_WAIT = 3'd3;
    localparam logic [2:0] S_LVL_GO   = 3'd4;
    localparam logic [2:0] S_LVL_WAIT = 3'd5;
    localparam logic [2:0] S_EMIT     = 3'd6;

    logic [2:0] state_reg;
    logic [2:0] state_next;
    logic       accept;

    assign in_ready = (state_reg == S_IDLE);
    assign accept   = in_valid && in_ready;

    // Sequence the block-end reduction, division and result hand-off
    always_comb
    begin
        state_next        = state_reg;
        cmd               = '0;
        cmd.accept        = accept;
        case (state_reg)
            S_IDLE:
            begin
                if (accept && last_of_block)
                begin
                    cmd.sum_clear = 1'b1;
                    state_next    = S_SUM;
                end
            end
            S_SUM:
            begin
                cmd.sum_step = 1'b1;
                if (status.sum_last)
                begin
                    state_next = S_AVG_GO;
                end
            end
            S_AVG_GO:
            begin
                cmd.div_start  = 1'b1;
                cmd.peak_clear = 1'b1;
                state_next     = S_AVG_WAIT;
            end
            S_AVG_WAIT:
            begin
                if (status.div_done)
                begin
                    state_next = S_LVL_GO;
                end
            end
            S_LVL_GO:
            begin
                cmd.div_start     = 1'b1;
                cmd.div_sel_level = 1'b1;
                state_next        = S_LVL_WAIT;
            end
            S_LVL_WAIT:
            begin
                cmd.div_sel_level = 1'b1;
                if (status.div_done)
                begin
                    state_next = S_EMIT;
                end
            end
            S_EMIT:
            begin
                if (!status.out_busy)
                begin
                    cmd.out_load = 1'b1;
                    state_next   = S_IDLE;
                end
            end
            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= S_IDLE;
        end
        else
        begin
            state_reg <= state_next;
        end
    end

endmodule

FILE: design/multichannel_peak_level_meter_top.sv
// Channel   Direction  Handshake             Payload
// input     in         in_valid / in_ready   sample, last_of_block
// result    out        out_valid / out_ready held_peak
// config    in         cfg_wr_en             cfg_index, cfg_wdata
//
// A sample without the block-end flag is accepted while the controller is idle. A
// block-end request, N being the active channel count, first sums the N channel
// peaks, then makes two passes through the one-bit-per-cycle divider.
// The result sits in an output register, so the next block starts while it waits.
// Reset clears peaks, position, held level, presets registers at once; no sweep.
// A stalled result stalls the block only when the next block end is ready to emit.
module multichannel_peak_level_meter_top #(
    parameter int MAX_CHANNELS = 8,
    parameter int SAMPLE_BITS  = 24
) (
    input  logic                               clk,
    input  logic                               rst_n,
    input  logic                               in_valid,
    output logic                               in_ready,
    input  logic signed [SAMPLE_BITS-1:0]      sample,
    input  logic                               last_of_block,
    output logic                               out_valid,
    input  logic                               out_ready,
    output logic [SAMPLE_BITS-1:0]             held_peak,
    input  logic                               cfg_wr_en,
    input  logic [plm_pkg::CFG_INDEX_BITS-1:0] cfg_index,
    input  logic [plm_pkg::CFG_DATA_BITS-1:0]  cfg_wdata
);

    import plm_pkg::*;

    ctrl_cmd_t  cmd;
    dp_status_t status;

    plm_ctrl u_ctrl (
        .clk           (clk),
        .rst_n         (rst_n),
        .in_valid      (in_valid),
        .last_of_block (last_of_block),
        .in_ready      (in_ready),
        .status        (status),
        .cmd           (cmd)
    );

    plm_datapath #(
        .MAX_CHANNELS (MAX_CHANNELS),
        .SAMPLE_BITS  (SAMPLE_BITS)
    ) u_dp (
        .clk           (clk),
        .rst_n         (rst_n),
        .cfg_wr_en     (cfg_wr_en),
        .cfg_index     (cfg_index),
        .cfg_wdata     (cfg_wdata),
        .sample        (sample),
        .last_of_block (last_of_block),
        .out_ready     (out_ready),
        .out_valid     (out_valid),
        .held_peak     (held_peak),
        .cmd           (cmd),
        .status        (status)
    );

    // The held level never decays
    assert property (@(posedge clk) disable iff (!rst_n)
        1'b1 |=> (held_peak >= $past(held_peak)))
    else $error("held level decreased");

    // Never load a result over one that is still waiting
    assert property (@(posedge clk) disable iff (!rst_n)
        cmd.out_load |-> !status.out_busy)
    else $error("result loaded while output register busy");

    // Divider completion is a single-cycle pulse
    assert property (@(posedge clk) disable iff (!rst_n)
        status.div_done |=> !status.div_done)
    else $error("divider done held for more than one cycle");

    // No sample enters while the peaks are being reduced
    assert property (@(posedge clk) disable iff (!rst_n)
        (cmd.sum_step || cmd.peak_clear || cmd.div_start) |-> !in_ready)
    else $error("input ready during block-end processing");

endmodule
